// File: design/distance_vector_table_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distance vector table update block
// Clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_ASSERT_SVH

// Same-cycle implication
`define DVTU_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dvtu: assertion failed");

// Next-cycle implication
`define DVTU_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dvtu: assertion failed");

`endif

// File: design/dvtu_pkg.sv
// ----------------------------------------------------------------------------
// dvtu_pkg
// Types and constants shared by the distance vector table update modules.
// ----------------------------------------------------------------------------
package dvtu_pkg;

   localparam int KIND_W = 2;
   localparam int SLOT_W = 4;
   localparam int ADDR_W = 32;
   localparam int ID_W   = 16;
   localparam int COST_W = 16;

   localparam logic [COST_W-1:0] INF_COST_RESET = 16'hFFFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_BEGIN  = 2'd1,
      KIND_ADVERT = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // one routing table entry as stored in the memory
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ID_W-1:0]   ident;
      logic [COST_W-1:0] cost;
      logic [ID_W-1:0]   hop;
      logic              dead;
   } entry_type;

endpackage

// File: design/distance_vector_table_update.sv
// ----------------------------------------------------------------------------
// distance_vector_table_update
// Distance-vector routing table with Bellman-Ford relaxation of advertised
// entries against the cost of the sending neighbor.
// ----------------------------------------------------------------------------
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  load, begin, advert, read item
//   rsp_        out        rsp_valid/rsp_stall  one result per item
//   csr_        in         csr_valid/csr_ready  infinity cost
//
// Load and read: each item passes through the access, result and idle steps.
// Begin and advertised entry: the single table read port visits one slot per
// cycle, write-back following in the cycle after the read.
// Reset clears all table entries at once through per-entry valid bits.
// A result still stalled when the next one is ready holds the block in its
// result step until that result transfers.
// ----------------------------------------------------------------------------
module distance_vector_table_update
   import dvtu_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [ID_W-1:0]   req_router_ident,
   input  logic [COST_W-1:0] req_path_cost,
   input  logic [ID_W-1:0]   req_hop,
   input  logic              req_dead_mark,
   input  logic              req_last_entry,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_table_changed,
   output logic              rsp_packet_done,
   output logic              rsp_sender_found,
   output logic [ID_W-1:0]   rsp_read_ident,
   output logic [COST_W-1:0] rsp_read_cost,
   output logic [ID_W-1:0]   rsp_read_hop,
   output logic              rsp_read_dead,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [COST_W-1:0] csr_infinity_cost
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [COST_W-1:0] infinity_cost_ff, infinity_cost_in;
   logic              tbl_wr_en;
   logic [IDX_W-1:0]  tbl_wr_addr;
   entry_type         tbl_wr_data;
   logic [IDX_W-1:0]  tbl_rd_addr;
   entry_type         tbl_rd_data;

   assign csr_ready        = 1'b1;
   assign infinity_cost_in = (csr_valid && csr_ready) ? csr_infinity_cost : infinity_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         infinity_cost_ff <= INF_COST_RESET;
      end else begin
         infinity_cost_ff <= infinity_cost_in;
      end
   end

   dvtu_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_slot          (req_slot),
      .req_address       (req_address),
      .req_router_ident  (req_router_ident),
      .req_path_cost     (req_path_cost),
      .req_hop           (req_hop),
      .req_dead_mark     (req_dead_mark),
      .req_last_entry    (req_last_entry),
      .infinity_cost     (infinity_cost_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_table_changed (rsp_table_changed),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_sender_found  (rsp_sender_found),
      .rsp_read_ident    (rsp_read_ident),
      .rsp_read_cost     (rsp_read_cost),
      .rsp_read_hop      (rsp_read_hop),
      .rsp_read_dead     (rsp_read_dead),
      .tbl_wr_en         (tbl_wr_en),
      .tbl_wr_addr       (tbl_wr_addr),
      .tbl_wr_data       (tbl_wr_data),
      .tbl_rd_addr       (tbl_rd_addr),
      .tbl_rd_data       (tbl_rd_data)
   );

   dvtu_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

endmodule

// File: design/dvtu_table.sv
// ----------------------------------------------------------------------------
// dvtu_table
// Routing table memory: one write port, one registered read port, and a
// valid bit per entry so that reset clears the whole table at once.
// ----------------------------------------------------------------------------
module dvtu_table
   import dvtu_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type                entry_mem_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                rd_data_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // never-written entries read as the cleared value
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: design/dvtu_seq.sv
// ----------------------------------------------------------------------------
// dvtu_seq
// Item sequencer: takes one item, accesses a slot or scans the table one slot
// per cycle in a read-modify-write pipeline, keeps sender state, holds result.
// ----------------------------------------------------------------------------
module dvtu_seq
   import dvtu_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [ID_W-1:0]   req_router_ident,
   input  logic [COST_W-1:0] req_path_cost,
   input  logic [ID_W-1:0]   req_hop,
   input  logic              req_dead_mark,
   input  logic              req_last_entry,
   input  logic [COST_W-1:0] infinity_cost,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_table_changed,
   output logic              rsp_packet_done,
   output logic              rsp_sender_found,
   output logic [ID_W-1:0]   rsp_read_ident,
   output logic [COST_W-1:0] rsp_read_cost,
   output logic [ID_W-1:0]   rsp_read_hop,
   output logic              rsp_read_dead,
   output logic              tbl_wr_en,
   output logic [IDX_W-1:0]  tbl_wr_addr,
   output entry_type         tbl_wr_data,
   output logic [IDX_W-1:0]  tbl_rd_addr,
   input  entry_type         tbl_rd_data
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_ACCESS = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]  p_idx_ff, p_idx_in;
   logic              sender_valid_ff, sender_valid_in;
   logic [COST_W-1:0] sender_cost_ff, sender_cost_in;
   logic [ID_W-1:0]   sender_ident_ff, sender_ident_in;
   logic              change_seen_ff, change_seen_in;

   // item registers
   kind_type          kind_ff, kind_in;
   logic              slot_ok_ff, slot_ok_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ID_W-1:0]   ident_ff, ident_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [ID_W-1:0]   hop_ff, hop_in;
   logic              dead_ff, dead_in;
   logic              last_ff, last_in;
   logic [COST_W:0]   sum_ff, sum_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_changed_ff, rsp_changed_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [ID_W-1:0]   rsp_ident_ff, rsp_ident_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic [ID_W-1:0]   rsp_hop_ff, rsp_hop_in;
   logic              rsp_dead_ff, rsp_dead_in;

   logic              item_read;

   assign req_stall   = (state_ff != S_IDLE);
   assign tbl_rd_addr = idx_ff;
   assign item_read   = (kind_ff == KIND_READ) && slot_ok_ff;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      p_valid_in      = 1'b0;
      p_idx_in        = idx_ff;
      sender_valid_in = sender_valid_ff;
      sender_cost_in  = sender_cost_ff;
      sender_ident_in = sender_ident_ff;
      change_seen_in  = change_seen_ff;
      kind_in         = kind_ff;
      slot_ok_in      = slot_ok_ff;
      addr_in         = addr_ff;
      ident_in        = ident_ff;
      cost_in         = cost_ff;
      hop_in          = hop_ff;
      dead_in         = dead_ff;
      last_in         = last_ff;
      sum_in          = sum_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_changed_in  = rsp_changed_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_ident_in    = rsp_ident_ff;
      rsp_cost_in     = rsp_cost_ff;
      rsp_hop_in      = rsp_hop_ff;
      rsp_dead_in     = rsp_dead_ff;
      tbl_wr_en       = 1'b0;
      tbl_wr_addr     = p_idx_ff;
      tbl_wr_data     = tbl_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = kind_type'(req_kind);
               slot_ok_in = (int'(req_slot) < TABLE_ENTRIES);
               addr_in    = req_address;
               ident_in   = req_router_ident;
               cost_in    = req_path_cost;
               hop_in     = req_hop;
               dead_in    = req_dead_mark;
               last_in    = req_last_entry;
               sum_in     = {1'b0, req_path_cost} + {1'b0, sender_cost_ff};
               case (kind_type'(req_kind))
                  KIND_LOAD, KIND_READ: begin
                     idx_in   = IDX_W'(req_slot);
                     state_in = S_ACCESS;
                  end
                  KIND_BEGIN: begin
                     sender_valid_in = 1'b0;
                     change_seen_in  = 1'b0;
                     idx_in          = '0;
                     state_in        = S_SCAN;
                  end
                  default: begin
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_ACCESS: begin
            if ((kind_ff == KIND_LOAD) && slot_ok_ff) begin
               tbl_wr_en           = 1'b1;
               tbl_wr_addr         = idx_ff;
               tbl_wr_data.address = addr_ff;
               tbl_wr_data.ident   = ident_ff;
               tbl_wr_data.cost    = cost_ff;
               tbl_wr_data.hop     = hop_ff;
               tbl_wr_data.dead    = dead_ff;
            end
            state_in = S_RESULT;
         end
         S_SCAN: begin
            p_valid_in = 1'b1;
            p_idx_in   = idx_ff;
            if (idx_ff == IDX_LAST) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_changed_in = change_seen_ff;
               rsp_done_in    = (kind_ff == KIND_ADVERT) && last_ff;
               rsp_found_in   = sender_valid_ff;
               rsp_ident_in   = item_read ? tbl_rd_data.ident : '0;
               rsp_cost_in    = item_read ? tbl_rd_data.cost : '0;
               rsp_hop_in     = item_read ? tbl_rd_data.hop : '0;
               rsp_dead_in    = item_read ? tbl_rd_data.dead : 1'b0;
               if ((kind_ff == KIND_ADVERT) && last_ff) begin
                  sender_valid_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // slot read last cycle; write-back goes to the slot that was read
      if (p_valid_ff) begin
         if (kind_ff == KIND_BEGIN) begin
            if (!sender_valid_ff && (tbl_rd_data.address == addr_ff)) begin
               sender_valid_in = 1'b1;
               sender_cost_in  = tbl_rd_data.cost;
               sender_ident_in = tbl_rd_data.ident;
            end
         end else if ((kind_ff == KIND_ADVERT) && sender_valid_ff) begin
            if ((tbl_rd_data.ident == ident_ff) && (sum_ff < {1'b0, tbl_rd_data.cost})) begin
               tbl_wr_en = 1'b1;
               if (tbl_rd_data.dead) begin
                  tbl_wr_data.cost = infinity_cost;
               end else begin
                  tbl_wr_data.cost = sum_ff[COST_W-1:0];
                  tbl_wr_data.hop  = sender_ident_ff;
               end
               change_seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         p_valid_ff      <= 1'b0;
         sender_valid_ff <= 1'b0;
         sender_cost_ff  <= '0;
         sender_ident_ff <= '0;
         change_seen_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         p_valid_ff      <= p_valid_in;
         sender_valid_ff <= sender_valid_in;
         sender_cost_ff  <= sender_cost_in;
         sender_ident_ff <= sender_ident_in;
         change_seen_ff  <= change_seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      p_idx_ff       <= p_idx_in;
      kind_ff        <= kind_in;
      slot_ok_ff     <= slot_ok_in;
      addr_ff        <= addr_in;
      ident_ff       <= ident_in;
      cost_ff        <= cost_in;
      hop_ff         <= hop_in;
      dead_ff        <= dead_in;
      last_ff        <= last_in;
      sum_ff         <= sum_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_dead_ff    <= rsp_dead_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_table_changed = rsp_changed_ff;
   assign rsp_packet_done   = rsp_done_ff;
   assign rsp_sender_found  = rsp_found_ff;
   assign rsp_read_ident    = rsp_ident_ff;
   assign rsp_read_cost     = rsp_cost_ff;
   assign rsp_read_hop      = rsp_hop_ff;
   assign rsp_read_dead     = rsp_dead_ff;

endmodule

// File: design/dvtu_checker.sv
// ----------------------------------------------------------------------------
// dvtu_checker
// Port-level checks for the distance vector table update block.
// ----------------------------------------------------------------------------
`include "distance_vector_table_update_assert.svh"

module dvtu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_table_changed,
   input logic        rsp_packet_done,
   input logic        rsp_sender_found,
   input logic [15:0] rsp_read_ident,
   input logic [15:0] rsp_read_cost,
   input logic [15:0] rsp_read_hop,
   input logic        rsp_read_dead
);

   logic [48:0] read_data;
   logic [51:0] rsp_payload;

   assign read_data   = {rsp_read_ident, rsp_read_cost, rsp_read_hop, rsp_read_dead};
   assign rsp_payload = {rsp_table_changed, rsp_packet_done, rsp_sender_found, read_data};

   // one item at a time: busy right after a transfer in
   `DVTU_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // a new result only comes out of a busy block
   `DVTU_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))

   // end of packet never carries read-back data
   `DVTU_ASSERT_IMPL(a_done_no_read, rsp_valid && rsp_packet_done, read_data == 49'd0)

   // stalled result holds
   `DVTU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind distance_vector_table_update dvtu_checker u_checker (.*);
